// ===== hw/rtl/pia_pkg.sv =====
package pia_pkg;

  localparam int VALUE_W = 32;
  localparam int NUM_DIGITS = 10;
  localparam int DIG_BITS = 4 * NUM_DIGITS;
  localparam int LEN_W = 4;
  localparam int MAX_PAD_WIDTH_DEF = 63;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_A     = 8'h41;

  typedef struct packed {
    logic               start;
    logic               hex;
    logic [VALUE_W-1:0] mag;
  } conv_req_t;

  // uppercase hex digit / decimal digit to ASCII
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + {4'd0, d};
    end else begin
      c = CHAR_A + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/pia_conv.sv =====
module pia_conv import pia_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  conv_req_t           req,
  output logic                done,
  output logic [DIG_BITS-1:0] digits
);

  localparam int CNT_W = $clog2(VALUE_W);

  logic                busy_r;
  logic                done_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [VALUE_W-1:0]  sh_r;
  logic [DIG_BITS-1:0] bcd_r;
  logic [DIG_BITS-1:0] adj;

  // shift-and-add-3: one input bit per cycle, every BCD digit corrected in parallel
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= !req.hex;
        done_r <= req.hex;
      end else if (busy_r && cnt_r == CNT_W'(VALUE_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt_r <= '0;
      sh_r  <= req.mag;
      if (req.hex) begin
        bcd_r <= DIG_BITS'(req.mag);
      end else begin
        bcd_r <= '0;
      end
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      sh_r  <= sh_r << 1;
      bcd_r <= {adj[DIG_BITS-2:0], sh_r[VALUE_W-1]};
    end
  end

  assign done   = done_r;
  assign digits = bcd_r;

endmodule

// ===== hw/rtl/padded_integer_to_ascii_core.sv =====
// Sequence: a bit-serial conversion for decimal or a direct load for hex, then a scan that strips
// leading zeros (up to 9), then the characters, one per cycle while out_ready is high.
// Items: one at a time; in_ready is high only in the idle state;
// the bit-serial binary-to-BCD shifter sets the decimal conversion time.
// Reset: synchronous, active low; clears the controller and the output valid.
module padded_integer_to_ascii_core import pia_pkg::*; #(
  parameter int MAX_PAD_WIDTH = MAX_PAD_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_value,
  input  logic        in_radix_hex,
  input  logic        in_signed_mode,
  input  logic        in_left_justify,
  input  logic        in_zero_pad,
  input  logic [5:0]  in_pad_width,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char_code,
  output logic        out_last
);

  localparam int PW = $clog2(MAX_PAD_WIDTH + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_PRE  = 3'd3;
  localparam logic [2:0] ST_TEXT = 3'd4;
  localparam logic [2:0] ST_POST = 3'd5;

  logic [2:0]          state_r;
  logic                left_r;
  logic                zpad_r;
  logic                neg_r;
  logic                sign_r;
  logic [PW-1:0]       width_r;
  logic [PW-1:0]       pad_r;
  logic [LEN_W-1:0]    ndig_r;
  logic [DIG_BITS-1:0] dig_r;
  logic                out_valid_r;
  logic [7:0]          out_char_r;
  logic                out_last_r;

  logic                in_acc;
  logic                adv;
  logic                neg_w;
  logic [PW-1:0]       width_cap;
  logic [LEN_W-1:0]    len_w;
  logic [PW-1:0]       npad_w;
  logic [3:0]          top_dig;
  logic [7:0]          pad_char;
  conv_req_t           req;
  logic                conv_done;
  logic [DIG_BITS-1:0] conv_digits;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign adv      = !out_valid_r || out_ready;
  assign neg_w    = !in_radix_hex && in_signed_mode && in_value[31];
  assign width_cap = (32'(in_pad_width) > 32'(MAX_PAD_WIDTH)) ? PW'(MAX_PAD_WIDTH)
                                                              : PW'(in_pad_width);
  assign len_w    = ndig_r + LEN_W'(neg_r);
  assign npad_w   = (width_r > PW'(len_w)) ? (width_r - PW'(len_w)) : '0;
  assign top_dig  = dig_r[DIG_BITS-1 -: 4];
  assign pad_char = zpad_r ? CHAR_ZERO : CHAR_SPACE;

  assign req.start = in_acc;
  assign req.hex   = in_radix_hex;
  assign req.mag   = neg_w ? (32'd0 - in_value) : in_value;

  pia_conv u_conv (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .done   (conv_done),
    .digits (conv_digits)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // emitting states reload the output themselves whenever it is taken
      if (out_ready && !(state_r == ST_PRE || state_r == ST_TEXT || state_r == ST_POST)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            state_r <= ST_CONV;
          end
        end
        ST_CONV: begin
          if (conv_done) begin
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (!(top_dig == 4'd0 && ndig_r > LEN_W'(1))) begin
            state_r <= (!left_r && npad_w != '0) ? ST_PRE : ST_TEXT;
          end
        end
        ST_PRE: begin
          if (adv) begin
            out_valid_r <= 1'b1;
            if (pad_r == PW'(1)) begin
              state_r <= ST_TEXT;
            end
          end
        end
        ST_TEXT: begin
          if (adv) begin
            out_valid_r <= 1'b1;
            if (!sign_r && ndig_r == LEN_W'(1)) begin
              state_r <= (left_r && pad_r != '0) ? ST_POST : ST_IDLE;
            end
          end
        end
        ST_POST: begin
          if (adv) begin
            out_valid_r <= 1'b1;
            if (pad_r == PW'(1)) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      left_r  <= in_left_justify;
      zpad_r  <= in_zero_pad;
      neg_r   <= neg_w;
      width_r <= width_cap;
    end
    if (conv_done) begin
      dig_r  <= conv_digits;
      ndig_r <= LEN_W'(NUM_DIGITS);
      sign_r <= neg_r;
    end
    // strip leading zeros, keeping at least one digit
    if (state_r == ST_SCAN) begin
      if (top_dig == 4'd0 && ndig_r > LEN_W'(1)) begin
        dig_r  <= dig_r << 4;
        ndig_r <= ndig_r - 1'b1;
      end else begin
        pad_r <= npad_w;
      end
    end
    if (adv) begin
      if (state_r == ST_PRE) begin
        out_char_r <= pad_char;
        out_last_r <= 1'b0;
        pad_r      <= pad_r - 1'b1;
      end else if (state_r == ST_TEXT) begin
        if (sign_r) begin
          out_char_r <= CHAR_MINUS;
          out_last_r <= 1'b0;
          sign_r     <= 1'b0;
        end else begin
          out_char_r <= digit_char(top_dig);
          out_last_r <= (ndig_r == LEN_W'(1)) && !(left_r && pad_r != '0);
          dig_r      <= dig_r << 4;
          ndig_r     <= ndig_r - 1'b1;
        end
      end else if (state_r == ST_POST) begin
        out_char_r <= pad_char;
        out_last_r <= (pad_r == PW'(1));
        pad_r      <= pad_r - 1'b1;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last      = out_last_r;

  a_conv_done_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
    conv_done |-> state_r == ST_CONV)
    else $error("conversion finished outside the conversion phase");

  a_text_has_digit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_TEXT |-> ndig_r != '0)
    else $error("text phase with no digit left");

  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (state_r == ST_TEXT || state_r == ST_POST) && state_r != ST_IDLE)
      |=> (out_last_r == (state_r == ST_IDLE)))
    else $error("last flag does not match the end of the item");

  a_accept_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_CONV)
    else $error("accepted item did not start conversion");

endmodule
